// ----- design/scsa_pkg.sv -----
// Shared types and constants for the size-class slot allocator.
`timescale 1ns / 1ps

package scsa_pkg;

  localparam int MIN_SHIFT   = 3;
  localparam int MAX_SHIFT   = 12;
  localparam int NUM_CLASSES = MAX_SHIFT - MIN_SHIFT;
  localparam int CLS_W       = 4;
  localparam int SHAMT_W     = $clog2(MAX_SHIFT);
  localparam int SIZE_W      = 16;
  localparam int OFF_W       = 17;
  localparam int SLOT_OUT_W  = 6;
  localparam int CNT_OUT_W   = 7;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SIZE      = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_OFFSET    = 2'd3
  } status_t;

  typedef struct packed {
    op_t               opcode;
    logic [SIZE_W-1:0] req_size;
    logic [OFF_W-1:0]  free_offset;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic [CLS_W-1:0]      size_class;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic [OFF_W-1:0]      byte_offset;
    logic [CNT_OUT_W-1:0]  free_count;
  } rsp_t;

  typedef struct packed {
    logic             unsupported;
    logic [CLS_W-1:0] cls;
  } class_sel_t;

  typedef struct packed {
    logic               left;
    logic [SHAMT_W-1:0] amount;
  } shift_ctl_t;

endpackage

// ----- design/scsa_classify.sv -----
// Size to class decoder: smallest power-of-two class that holds the size.
`timescale 1ns / 1ps

module scsa_classify import scsa_pkg::*; (
  input  logic [SIZE_W-1:0] size,
  output class_sel_t        sel
);

  // Walk from the largest class down so the smallest fitting class wins.
  always_comb begin
    sel.unsupported = 1'b1;
    sel.cls         = '0;
    for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
      if (OFF_W'(size) <= (OFF_W'(1) << (k + MIN_SHIFT))) begin
        sel.unsupported = 1'b0;
        sel.cls         = CLS_W'(k);
      end
    end
  end

endmodule

// ----- design/scsa_shift.sv -----
// Shared barrel shifter: offset to slot on the way in, slot to offset on the way out.
`timescale 1ns / 1ps

module scsa_shift import scsa_pkg::*; (
  input  shift_ctl_t       ctl,
  input  logic [OFF_W-1:0] data,
  output logic [OFF_W-1:0] result
);

  assign result = ctl.left ? (data << ctl.amount) : (data >> ctl.amount);

endmodule

// ----- design/size_class_slot_allocator.sv -----
// Top level: sequencer, class heads and counts, and the free-list link memory.
//
// Requests come in on req (req_valid / req_stall) as one word each: an alloc
// or a free with a byte size, plus the offset to free. Every request gives
// exactly one response word on rsp (rsp_valid / rsp_stall) with status,
// class, slot, aligned byte offset and the free count left in the class.
// A word moves at a clock edge where valid is high and stall is low.
// One request is worked at a time, stepping through a single shared shifter
// and one link memory port: a successful alloc steps S_EXEC, S_POP, S_OFFSET,
// S_RESULT, a successful free skips S_POP, a refused request goes from S_EXEC
// to S_RESULT. The response word is registered from S_RESULT, and the next
// request is taken in S_IDLE after it. The steps come from the link read and
// one shifter pass on an alloc, and two shifter passes on a free.
// After rst (synchronous, active high) the link memory is rewritten to
// ascending order, one entry a cycle; req_stall stays high meanwhile.
// While rsp_stall is high a waiting response holds; one more request may be
// taken, but it then waits in S_RESULT and no request after it is taken.
`timescale 1ns / 1ps

module size_class_slot_allocator import scsa_pkg::*; #(
  parameter int SLOTS_PER_CLASS = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int SW = $clog2(SLOTS_PER_CLASS);
  localparam int LW = $clog2(SLOTS_PER_CLASS + 1);
  localparam logic [LW-1:0] LINK_END = LW'(SLOTS_PER_CLASS);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_EXEC   = 6'b000100,
    S_POP    = 6'b001000,
    S_OFFSET = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  state_t state;

  logic [CLS_W-1:0] clr_cls;
  logic [SW-1:0]    clr_slot;

  logic [LW-1:0] class_head [NUM_CLASSES];
  logic [LW-1:0] slots_free [NUM_CLASSES];
  logic [LW-1:0] link_mem   [NUM_CLASSES][SLOTS_PER_CLASS];
  logic [LW-1:0] link_rdata;

  op_t              op_r;
  logic [OFF_W-1:0] foff_r;
  logic [CLS_W-1:0] cls_r;
  logic             unsup_r;
  logic [SW-1:0]    slot_r;
  logic [LW-1:0]    cnt_r;
  logic [OFF_W-1:0] offset_r;
  status_t          status_r;

  class_sel_t       sel;
  shift_ctl_t       sh_ctl;
  logic [OFF_W-1:0] sh_data;
  logic [OFF_W-1:0] sh_res;

  logic [LW-1:0]    head;
  logic [LW-1:0]    cnt;
  logic             accept;
  logic             exhausted;
  logic             free_bad;
  logic             rsp_free;
  logic             link_re;
  logic             link_we;
  logic [CLS_W-1:0] link_wcls;
  logic [SW-1:0]    link_wslot;
  logic [LW-1:0]    link_wdata;

  scsa_classify u_classify (
    .size (req.req_size),
    .sel  (sel)
  );

  // Right shift turns the free offset into a slot; left shift builds the offset.
  assign sh_ctl.left   = (state == S_OFFSET);
  assign sh_ctl.amount = SHAMT_W'(cls_r) + SHAMT_W'(MIN_SHIFT);
  assign sh_data       = (state == S_OFFSET) ? OFF_W'(slot_r) : foff_r;

  scsa_shift u_shift (
    .ctl    (sh_ctl),
    .data   (sh_data),
    .result (sh_res)
  );

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  assign head      = class_head[cls_r];
  assign cnt       = slots_free[cls_r];
  assign exhausted = (cnt == '0) || (head >= LINK_END);
  assign free_bad  = (sh_res >= OFF_W'(SLOTS_PER_CLASS)) || (cnt >= LINK_END);

  assign link_re = (state == S_EXEC) && !unsup_r && (op_r == OP_ALLOC) && !exhausted;

  always_comb begin
    if (state == S_CLEAR) begin
      link_we    = 1'b1;
      link_wcls  = clr_cls;
      link_wslot = clr_slot;
      link_wdata = LW'(clr_slot) + LW'(1);
    end else begin
      link_we    = (state == S_EXEC) && !unsup_r && (op_r == OP_FREE) && !free_bad;
      link_wcls  = cls_r;
      link_wslot = sh_res[SW-1:0];
      link_wdata = head;
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wcls][link_wslot] <= link_wdata;
    end
    if (link_re) begin
      link_rdata <= link_mem[cls_r][head[SW-1:0]];
    end
  end

  // Sequencer and per-class list state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cls   <= '0;
      clr_slot  <= '0;
      rsp_valid <= 1'b0;
      for (int k = 0; k < NUM_CLASSES; k++) begin
        class_head[k] <= '0;
        slots_free[k] <= LINK_END;
      end
    end else begin
      // Raise for a finished request, else drop once the word is taken.
      if (state == S_RESULT && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_slot == SW'(SLOTS_PER_CLASS - 1)) begin
            clr_slot <= '0;
            if (clr_cls == CLS_W'(NUM_CLASSES - 1)) begin
              state <= S_IDLE;
            end else begin
              clr_cls <= clr_cls + CLS_W'(1);
            end
          end else begin
            clr_slot <= clr_slot + SW'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (unsup_r) begin
            state <= S_RESULT;
          end else if (op_r == OP_ALLOC) begin
            state <= exhausted ? S_RESULT : S_POP;
          end else if (free_bad) begin
            state <= S_RESULT;
          end else begin
            // push: freed slot becomes the head
            class_head[cls_r] <= LW'(sh_res[SW-1:0]);
            slots_free[cls_r] <= cnt + LW'(1);
            state             <= S_OFFSET;
          end
        end
        S_POP: begin
          class_head[cls_r] <= link_rdata;
          slots_free[cls_r] <= cnt - LW'(1);
          state             <= S_OFFSET;
        end
        S_OFFSET: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  // Request fields and result assembly.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= req.opcode;
      foff_r  <= req.free_offset;
      cls_r   <= sel.cls;
      unsup_r <= sel.unsupported;
    end
    if (state == S_EXEC) begin
      offset_r <= '0;
      if (unsup_r) begin
        status_r <= ST_SIZE;
        slot_r   <= '0;
        cnt_r    <= '0;
      end else if (op_r == OP_ALLOC) begin
        if (exhausted) begin
          status_r <= ST_EXHAUSTED;
          slot_r   <= '0;
          cnt_r    <= cnt;
        end else begin
          status_r <= ST_OK;
          slot_r   <= head[SW-1:0];
          cnt_r    <= cnt - LW'(1);
        end
      end else if (free_bad) begin
        status_r <= ST_OFFSET;
        slot_r   <= '0;
        cnt_r    <= cnt;
      end else begin
        status_r <= ST_OK;
        slot_r   <= sh_res[SW-1:0];
        cnt_r    <= cnt + LW'(1);
      end
    end
    if (state == S_OFFSET) begin
      offset_r <= sh_res;
    end
    if (state == S_RESULT && rsp_free) begin
      rsp.status      <= status_r;
      rsp.size_class  <= cls_r;
      rsp.slot_index  <= SLOT_OUT_W'(slot_r);
      rsp.byte_offset <= offset_r;
      rsp.free_count  <= CNT_OUT_W'(cnt_r);
    end
  end

`ifndef SYNTHESIS
  a_clear_stall : assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> req_stall)
    else $error("request taken during link clearing");

  a_pop_nonempty : assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> (slots_free[cls_r] != '0) && !unsup_r && (op_r == OP_ALLOC))
    else $error("pop from an empty or refused class");

  a_rsp_from_result : assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_RESULT))
    else $error("response raised outside result step");

  a_link_write_free : assert property (@(posedge clk) disable iff (rst)
    (link_we && state != S_CLEAR) |-> (op_r == OP_FREE) && !unsup_r && !free_bad)
    else $error("link write without a legal free");
`endif

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the size-class slot allocator.
`timescale 1ns / 1ps

module tb_top;
  import scsa_pkg::*;

  localparam int SLOTS        = 64;
  localparam int RANDOM_ITEMS = 1500;
  localparam int PHASE_LEN    = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_PCT     = 27;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    int cls;
    int off;
  } held_slot_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // shadow allocator state
  logic [6:0] next_slot [NUM_CLASSES][SLOTS];
  logic [6:0] head_slot [NUM_CLASSES];
  logic [6:0] free_slots [NUM_CLASSES];

  req_t       req_backlog_q[$];
  rsp_t       rsp_due_q[$];
  held_slot_t held_slots[$];

  logic req_taken = 1'b0;
  logic calm = 1'b0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   errors = 0;
  int   cycles = 0;

  size_class_slot_allocator #(.SLOTS_PER_CLASS(SLOTS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Update the shadow state for one accepted request and return its response.
  function automatic rsp_t apply_request(req_t r);
    rsp_t       o;
    int         k;
    int         c;
    int         sh;
    int         slot;
    int         i;
    logic [6:0] cnt;
    o = '0;
    k = -1;
    for (c = NUM_CLASSES - 1; c >= 0; c--)
      if (int'(r.req_size) <= (1 << (c + MIN_SHIFT))) k = c;
    if (k < 0) begin
      o.status = ST_SIZE;
      return o;
    end
    sh = k + MIN_SHIFT;
    cnt = free_slots[k];
    o.size_class = 4'(k);
    o.free_count = cnt;
    if (r.opcode == OP_ALLOC) begin
      if (cnt == 0 || head_slot[k] >= SLOTS) begin
        o.status = ST_EXHAUSTED;
        return o;
      end
      slot = int'(head_slot[k]);
      head_slot[k] = next_slot[k][slot];
      free_slots[k] = 7'(cnt - 1);
      held_slots.push_back('{k, slot << sh});
    end else begin
      slot = int'(r.free_offset) >> sh;
      if (slot >= SLOTS || cnt >= SLOTS) begin
        o.status = ST_OFFSET;
        return o;
      end
      next_slot[k][slot] = head_slot[k];
      head_slot[k] = 7'(slot);
      free_slots[k] = 7'(cnt + 1);
      for (i = 0; i < held_slots.size(); i++)
        if (held_slots[i].cls == k && held_slots[i].off == (slot << sh)) begin
          held_slots.delete(i);
          break;
        end
    end
    o.status = ST_OK;
    o.slot_index = 6'(slot);
    o.byte_offset = 17'(slot << sh);
    o.free_count = free_slots[k];
    return o;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic queue_req(op_t op, int size, int off);
    req_backlog_q.push_back('{op, 16'(size), 17'(off)});
  endtask

  // driver: offer a new word only when the current one is gone
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (req_backlog_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        req <= req_backlog_q.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall plus one long hold
  always @(negedge clk) begin
    if (hold_left != 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      rsp_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // monitor: check responses first, then predict the request taken at this edge
  always @(posedge clk) begin : monitor
    rsp_t want;
    req_taken <= req_valid && !req_stall;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (rsp_due_q.size() == 0) begin
        $error("response word with nothing expected");
        errors++;
      end else begin
        want = rsp_due_q.pop_front();
        check_field("status", int'(want.status), int'(rsp.status));
        check_field("size_class", int'(want.size_class), int'(rsp.size_class));
        check_field("slot_index", int'(want.slot_index), int'(rsp.slot_index));
        check_field("byte_offset", int'(want.byte_offset), int'(rsp.byte_offset));
        check_field("free_count", int'(want.free_count), int'(rsp.free_count));
      end
    end
    if (!rst && req_valid && !req_stall)
      rsp_due_q.push_back(apply_request(req));
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("size_class_slot_allocator verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int   n;
    int   k;
    int   s;
    int   hi;
    int   idx;
    int   focus;
    bit   draining;
    bit   want_free;
    req_t r;
    int   cands[$];
    for (k = 0; k < NUM_CLASSES; k++) begin
      for (s = 0; s < SLOTS; s++) next_slot[k][s] = 7'(s + 1);
      head_slot[k] = '0;
      free_slots[k] = 7'(SLOTS);
    end
    focus = 0;
    draining = 1'b0;

    queue_req(OP_ALLOC, 0, 0);            // size zero lands in the smallest class
    queue_req(OP_ALLOC, 8, 131071);       // offset ignored on alloc
    queue_req(OP_ALLOC, 9, 0);
    queue_req(OP_ALLOC, 1, 0);
    queue_req(OP_ALLOC, 2048, 0);
    queue_req(OP_ALLOC, 1025, 0);
    queue_req(OP_ALLOC, 2049, 0);         // just above the largest class
    queue_req(OP_FREE, 65535, 131071);    // oversize free
    queue_req(OP_ALLOC, 65535, 0);
    queue_req(OP_FREE, 8, 13);            // unaligned, drop low bits
    queue_req(OP_FREE, 8, 512);           // slot past the pool
    queue_req(OP_FREE, 2048, 131071);     // double free of a slot still listed
    queue_req(OP_FREE, 5, 0);
    queue_req(OP_FREE, 7, 16);            // pool back to full
    queue_req(OP_FREE, 3, 16);            // free into a full pool
    queue_req(OP_FREE, 16, 32);           // never-allocated slot, not detected
    queue_req(OP_FREE, 512, 0);
    queue_req(OP_ALLOC, 1024, 0);
    queue_req(OP_FREE, 1024, 1023);
    queue_req(OP_ALLOC, 2048, 0);
    queue_req(OP_ALLOC, 2048, 0);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      while (req_backlog_q.size() >= 2) @(negedge clk);
      if (n == 300) hold_go <= 1'b1;
      if (n == 600) calm <= 1'b1;
      if (n == 800) calm <= 1'b0;
      if (n == 1000)
        while (req_backlog_q.size() != 0 || req_valid || rsp_due_q.size() != 0)
          @(negedge clk);
      // alternate phases that drain or refill one randomly chosen class
      if (n % PHASE_LEN == 0) begin
        focus = $urandom_range(0, NUM_CLASSES - 1);
        draining = !draining;
      end
      idx = $urandom_range(0, 99);
      if (idx < 8) begin
        r.opcode = op_t'($urandom_range(0, 1));
        r.req_size = 16'($urandom);
        r.free_offset = 17'($urandom);
      end else if (idx < 12) begin
        r.opcode = op_t'($urandom_range(0, 1));
        r.req_size = 16'($urandom_range(65535, 2049));
        r.free_offset = 17'($urandom);
      end else begin
        k = ($urandom_range(0, 99) < 70) ? focus : $urandom_range(0, NUM_CLASSES - 1);
        hi = 1 << (k + MIN_SHIFT);
        r.req_size = 16'($urandom_range(hi, (k == 0) ? 0 : hi / 2 + 1));
        r.free_offset = 17'($urandom);
        want_free = $urandom_range(0, 99) < (draining ? 15 : 85);
        r.opcode = want_free ? OP_FREE : OP_ALLOC;
        if (want_free) begin
          cands.delete();
          foreach (held_slots[i])
            if (held_slots[i].cls == k) cands.push_back(i);
          if (cands.size() != 0 && $urandom_range(0, 99) < 90) begin
            idx = cands[$urandom_range(0, cands.size() - 1)];
            r.free_offset = 17'(held_slots[idx].off + $urandom_range(0, hi - 1));
          end else begin
            r.free_offset = 17'($urandom_range(0, (SLOTS << (k + MIN_SHIFT)) - 1));
          end
        end
      end
      req_backlog_q.push_back(r);
    end

    while (req_backlog_q.size() != 0 || req_valid) @(negedge clk);
    while (rsp_due_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0)
      $display("size_class_slot_allocator verification clean");
    else
      $display("size_class_slot_allocator verification failed");
    $finish;
  end

endmodule
